// ----- hdl/bmf_pkg.sv -----
// shared types, constants and helpers for the binary map free cell finder
// no dependencies
`default_nettype none

package bmf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int DIM_W = 11;
  localparam int PIX_W = 8;
  localparam int PT_W  = 10;

  // line store entry: bit 1 row two above, bit 0 row above
  localparam int LINE_W = 2;

  // window shift keeps the two older columns of each row
  localparam logic [8:0] WIN_SHIFT_MASK = 9'h1B6;

  typedef enum logic [0:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             cur;
  } bmf_item_t;

  typedef struct packed {
    logic [PT_W-1:0] x;
    logic [PT_W-1:0] y;
  } bmf_point_t;

  // zero reads as one, anything past the maximum saturates
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/bmf_line_ram.sv -----
// line store memory: one entry per column, two obstacle bits per entry
// depends on bmf_pkg
`default_nettype none

module bmf_line_ram import bmf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [COL_W-1:0]  wr_addr,
  input  wire logic [LINE_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [COL_W-1:0]  rd_addr,
  output logic      [LINE_W-1:0] rd_data
);

  logic [LINE_W-1:0] mem [MAX_WIDTH];
  logic [LINE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read before write on a same-address collision
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- hdl/bmf_window.sv -----
// 3x3 obstacle window, border test and result coordinates
// depends on bmf_pkg
`default_nettype none

module bmf_window import bmf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              advance,
  input  wire bmf_item_t         item,
  input  wire logic [LINE_W-1:0] line_bits,
  input  wire logic [DIM_W-1:0]  dim_w,
  input  wire logic [DIM_W-1:0]  dim_h,
  output logic                   hit,
  output bmf_point_t             point,
  output logic      [LINE_W-1:0] wr_bits
);

  logic [8:0]       win_r;
  logic [8:0]       win_nxt;
  logic             up;
  logic             mid;
  logic             in_border;
  logic [DIM_W-1:0] col_ext;
  logic [DIM_W-1:0] row_ext;
  logic [DIM_W-1:0] x_diff;

  assign up  = line_bits[1];
  assign mid = line_bits[0];

  // top row in bits 2..0, middle 5..3, bottom 8..6, newest column lowest
  assign win_nxt = ((win_r << 1) & WIN_SHIFT_MASK) |
                   {2'b00, item.cur, 2'b00, mid, 2'b00, up};

  assign col_ext = {1'b0, item.col};
  assign row_ext = {1'b0, item.row};

  // centre sits one row up and one column left; keep it off the border
  assign in_border = (col_ext >= DIM_W'(2)) && (col_ext <= dim_w - DIM_W'(1)) &&
                     (row_ext >= DIM_W'(2)) && (row_ext <= dim_h - DIM_W'(1));

  // centre and all eight neighbours must be free
  assign hit = in_border && (win_nxt == '0);

  assign x_diff  = dim_w - col_ext;
  assign point.x = x_diff[PT_W-1:0];
  assign point.y = PT_W'(item.row - ROW_W'(1));

  // row above moves up, current pixel becomes the row above
  assign wr_bits = {mid, item.cur};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (advance) begin
      win_r <= win_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/binary_map_free_cell_finder.sv -----
// top level of the binary map free cell finder: counters, line store control,
// forwarding and output register; depends on bmf_pkg, bmf_line_ram, bmf_window
`default_nettype none

// Streaming 3x3 binary erosion over an occupancy map. Pixels come in raster
// order, one beat per pixel; any nonzero pixel is an obstacle. For each pixel
// the block tests the cell one row up and one column left, and when that cell
// and its eight neighbours are all free and it is off the image border, one
// result beat carries its mirrored column (width - column - 1) and its row.
// A pixel is taken every clock while results flow: the line store is read
// when a pixel is taken and written back when that pixel leaves stage one,
// with a forwarding path for back-to-back pixels in the same column (width
// one). A result is registered in the output register, which also decouples
// the two sides. After reset the line store is cleared one entry a cycle, so
// the input stalls until all 1024 entries are clear. Width and height come
// from the configuration registers (zero reads as one, values above 1024
// saturate) and must be written only while the block is idle.

module binary_map_free_cell_finder import bmf_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // configuration
  input  wire logic             cfg_wr_en,
  input  wire logic [0:0]       cfg_index,
  input  wire logic [DIM_W-1:0] cfg_wr_data,
  // pixel channel
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [PIX_W-1:0] in_pixel_value,
  // result channel
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic      [PT_W-1:0]  out_point_x,
  output logic      [PT_W-1:0]  out_point_y
);

  // configuration registers
  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] height_r;
  logic [DIM_W-1:0] dim_w;
  logic [DIM_W-1:0] dim_h;

  // position of the next pixel
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic [DIM_W-1:0] col_inc;
  logic [DIM_W-1:0] row_inc;

  // line store clearing pass
  logic             clr_r;
  logic [COL_W-1:0] clr_addr_r;

  // second stage: line data back from the memory
  logic              s1_v_r;
  bmf_item_t         s1_item_r;
  logic              s1_go;
  logic              in_beat;
  bmf_item_t         in_item;

  // forwarding for a read that raced the write of the same entry
  logic              fwd_v_r;
  logic [LINE_W-1:0] fwd_bits_r;
  logic [LINE_W-1:0] rd_data;
  logic [LINE_W-1:0] line_bits;
  logic [LINE_W-1:0] wr_bits;

  // memory port
  logic              mem_wr_en;
  logic [COL_W-1:0]  mem_wr_addr;
  logic [LINE_W-1:0] mem_wr_data;

  // result
  logic       hit;
  bmf_point_t point;
  logic       out_valid_r;
  bmf_point_t out_point_r;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(MAX_WIDTH);
      height_r <= DIM_W'(MAX_HEIGHT);
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_IMAGE_WIDTH:  width_r  <= cfg_wr_data;
        CFG_IMAGE_HEIGHT: height_r <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  assign dim_w = clamp_dim(width_r, DIM_W'(MAX_WIDTH));
  assign dim_h = clamp_dim(height_r, DIM_W'(MAX_HEIGHT));

  // ------------------------------------------------------------ handshakes
  // stage one moves on when the output register is free or being drained
  assign s1_go    = s1_v_r && (!out_valid_r || !out_stall);
  assign in_stall = clr_r || (s1_v_r && !s1_go);
  assign in_beat  = in_valid && !in_stall;

  assign in_item.col = col_r;
  assign in_item.row = row_r;
  assign in_item.cur = |in_pixel_value;

  // -------------------------------------------------------------- counters
  assign col_inc = {1'b0, col_r} + DIM_W'(1);
  assign row_inc = {1'b0, row_r} + DIM_W'(1);

  // a counter past a shrunken dimension wraps at its next step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_beat) begin
      if (col_inc >= dim_w) begin
        col_r <= '0;
        row_r <= (row_inc >= dim_h) ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_r <= col_inc[COL_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------- clear pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_r) begin
      clr_addr_r <= clr_addr_r + COL_W'(1);
      if (clr_addr_r == COL_W'(MAX_WIDTH - 1)) begin
        clr_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------- stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_beat) begin
      s1_v_r <= 1'b1;
    end else if (s1_go) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_item_r <= in_item;
    end
  end

  // the write of the item ahead lands on the same edge as this read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_v_r <= 1'b0;
    end else if (in_beat) begin
      fwd_v_r <= s1_go && (s1_item_r.col == col_r);
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      fwd_bits_r <= wr_bits;
    end
  end

  assign line_bits = fwd_v_r ? fwd_bits_r : rd_data;

  // ---------------------------------------------------------- line store
  assign mem_wr_en   = clr_r || s1_go;
  assign mem_wr_addr = clr_r ? clr_addr_r : s1_item_r.col;
  assign mem_wr_data = clr_r ? '0 : wr_bits;

  bmf_line_ram u_line_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (in_beat),
    .rd_addr (col_r),
    .rd_data (rd_data)
  );

  bmf_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (s1_go),
    .item      (s1_item_r),
    .line_bits (line_bits),
    .dim_w     (dim_w),
    .dim_h     (dim_h),
    .hit       (hit),
    .point     (point),
    .wr_bits   (wr_bits)
  );

  // ------------------------------------------------------ output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= hit;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && hit) begin
      out_point_r <= point;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_point_x = out_point_r.x;
  assign out_point_y = out_point_r.y;

`ifndef SYNTH
  // a new result beat only ever comes from a stage one advance
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_go))
    else $error("result beat without a stage one advance");

  // the forward flag is only raised by a pixel beat
  a_fwd_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(fwd_v_r) |-> $past(in_beat))
    else $error("forward flag set without a preceding pixel");

  // no pixel reaches stage one while the clear pass runs
  a_no_pixel_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |=> !s1_v_r)
    else $error("pixel taken during line store clear");

  // the column advances by one inside a row
  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && (col_inc < dim_w)) |=> (col_r == $past(col_inc[COL_W-1:0])))
    else $error("column counter skipped");
`endif

endmodule

`default_nettype wire
